>>> hw/rtl/hsvrgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB pixel pipeline.
// No dependencies.
package hsvrgb_pkg;

  localparam int unsigned HUE_W    = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PROD_W   = 16;  // b*s and b*(255-s)
  localparam int unsigned WEIGHT_W = 13;  // 0..7680
  localparam int unsigned BW_W     = PROD_W + WEIGHT_W;
  localparam int unsigned T_W      = BW_W - 9;  // b*s*w / 512
  localparam int unsigned SEC_W    = 3;

  localparam logic [WEIGHT_W-1:0] SECTOR_CODES = 13'd7680;
  localparam logic [CHAN_W-1:0]   FULL_SCALE   = 8'd255;
  // floor(2^24 / 15): underestimating reciprocal, fixed by one correction step
  localparam logic [20:0]         RECIP15      = 21'd1118481;
  // 257 / 2^16 underestimates 1/255, fixed by one correction step
  localparam logic [8:0]          RECIP255     = 9'd257;

  localparam logic [SEC_W-1:0] SECTOR_GRAY = 3'd6;

  // Stage record leaving the front end
  typedef struct packed {
    logic                  valid;
    logic [SEC_W-1:0]      sector;
    logic [CHAN_W-1:0]     bright;
    logic [PROD_W-1:0]     prod_a;   // b*(255-s)
    logic [BW_W-1:0]       prod_bw;  // b*s*w
  } prep_t;

  // Stage record leaving the quotient section
  typedef struct packed {
    logic                  valid;
    logic [SEC_W-1:0]      sector;
    logic [CHAN_W-1:0]     bright;
    logic [CHAN_W-1:0]     gray;     // floor(b*(255-s)/255)
    logic [PROD_W-1:0]     y;        // floor(x numerator / 7680)
    logic [CHAN_W-1:0]     xest;     // y/255, may be one low
  } quot_t;

  function automatic logic [SEC_W-1:0] sector_of(input logic [HUE_W-1:0] hue);
    logic [SEC_W-1:0] sec;
    sec = SECTOR_GRAY;
    if (hue < 16'd7680) begin
      sec = 3'd0;
    end else if (hue < 16'd15360) begin
      sec = 3'd1;
    end else if (hue < 16'd23040) begin
      sec = 3'd2;
    end else if (hue < 16'd30720) begin
      sec = 3'd3;
    end else if (hue < 16'd38400) begin
      sec = 3'd4;
    end else if (hue < 16'd46080) begin
      sec = 3'd5;
    end
    return sec;
  endfunction

  function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_W-1:0] sec);
    logic [HUE_W-1:0] base;
    case (sec)
      3'd1:    base = 16'd7680;
      3'd2:    base = 16'd15360;
      3'd3:    base = 16'd23040;
      3'd4:    base = 16'd30720;
      3'd5:    base = 16'd38400;
      default: base = 16'd0;
    endcase
    return base;
  endfunction

endpackage

>>> hw/rtl/hsvrgb_prep.sv
// Front end: hue sector and weight, chroma products, then b*s*w.
// Depends on hsvrgb_pkg. Two register stages.
module hsvrgb_prep
  import hsvrgb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_valid,
  input  logic [HUE_W-1:0]    hue,
  input  logic [CHAN_W-1:0]   saturation,
  input  logic [CHAN_W-1:0]   brightness,
  output prep_t               stage_o
);

  // stage 1
  logic                  v1_r;
  logic [SEC_W-1:0]      sec1_r, sec1_nxt;
  logic [WEIGHT_W-1:0]   w1_r, w1_nxt;
  logic [CHAN_W-1:0]     b1_r;
  logic [PROD_W-1:0]     pa1_r, pa1_nxt;
  logic [PROD_W-1:0]     pb1_r, pb1_nxt;
  logic [HUE_W-1:0]      offset;
  logic [WEIGHT_W-1:0]   off13;
  // stage 2
  prep_t                 s2_r, s2_nxt;

  always_comb begin
    sec1_nxt = sector_of(hue);
    offset   = hue - sector_base(sec1_nxt);
    off13    = offset[WEIGHT_W-1:0];
    // rising edge in even sectors, falling in odd ones; gray hues carry no weight
    if (sec1_nxt == SECTOR_GRAY) begin
      w1_nxt = '0;
    end else begin
      w1_nxt = sec1_nxt[0] ? (SECTOR_CODES - off13) : off13;
    end
    pa1_nxt  = PROD_W'(brightness) * PROD_W'(FULL_SCALE - saturation);
    pb1_nxt  = PROD_W'(brightness) * PROD_W'(saturation);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sec1_r <= sec1_nxt;
      w1_r   <= w1_nxt;
      b1_r   <= brightness;
      pa1_r  <= pa1_nxt;
      pb1_r  <= pb1_nxt;
    end
  end

  always_comb begin
    s2_nxt.valid   = v1_r;
    s2_nxt.sector  = sec1_r;
    s2_nxt.bright  = b1_r;
    s2_nxt.prod_a  = pa1_r;
    s2_nxt.prod_bw = BW_W'(pb1_r) * BW_W'(w1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (ce) begin
      s2_r.valid <= s2_nxt.valid;
    end
    if (ce) begin
      s2_r.sector  <= s2_nxt.sector;
      s2_r.bright  <= s2_nxt.bright;
      s2_r.prod_a  <= s2_nxt.prod_a;
      s2_r.prod_bw <= s2_nxt.prod_bw;
    end
  end

  assign stage_o = s2_r;

  // both products split 255*b
  a_prod_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (17'(pa1_r) + 17'(pb1_r)) == 17'(b1_r) * 17'(FULL_SCALE))
    else $error("chroma products do not sum to 255*b");

  // weight never exceeds one sector
  a_weight: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && sec1_r != SECTOR_GRAY |-> w1_r <= SECTOR_CODES)
    else $error("hue weight out of range");

  a_bw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r.valid |-> (s2_r.prod_bw >> 9) <= 20'd975375)
    else $error("b*s*w out of range");

endmodule

>>> hw/rtl/hsvrgb_quot.sv
// Quotient section: divides by 15 and by 255 with reciprocal multiplies.
// Depends on hsvrgb_pkg. Three register stages.
module hsvrgb_quot
  import hsvrgb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   ce,
  input  prep_t  stage_i,
  output quot_t  stage_o
);

  // stage 3: reciprocal estimates
  logic                 v3_r;
  logic [SEC_W-1:0]     sec3_r;
  logic [CHAN_W-1:0]    b3_r;
  logic [PROD_W-1:0]    a3_r;
  logic [T_W-1:0]       t3_r, t3_nxt;
  logic [PROD_W-1:0]    q3_r, q3_nxt;
  logic [CHAN_W-1:0]    g3_r, g3_nxt;
  logic [40:0]          q_full;
  logic [24:0]          g_full;

  // stage 4: corrected quotients
  logic                 v4_r;
  logic [SEC_W-1:0]     sec4_r;
  logic [CHAN_W-1:0]    b4_r;
  logic [PROD_W-1:0]    y4_r, y4_nxt;
  logic [CHAN_W-1:0]    g4_r, g4_nxt;
  logic [T_W-1:0]       rem15;
  logic [PROD_W-1:0]    qx;
  logic [PROD_W-1:0]    remg;

  // stage 5: estimate of y/255
  quot_t                s5_r;
  logic [24:0]          x_full;

  always_comb begin
    t3_nxt = stage_i.prod_bw[BW_W-1:9];
    q_full = 41'(t3_nxt) * 41'(RECIP15);
    q3_nxt = q_full[39:24];
    g_full = 25'(stage_i.prod_a) * 25'(RECIP255);
    g3_nxt = g_full[23:16];
  end

  always_comb begin
    rem15  = t3_r - T_W'(q3_r) * T_W'(15);
    qx     = q3_r + PROD_W'(rem15 >= T_W'(15));
    y4_nxt = a3_r + qx;
    remg   = a3_r - PROD_W'(g3_r) * PROD_W'(FULL_SCALE);
    g4_nxt = g3_r + CHAN_W'(remg >= PROD_W'(FULL_SCALE));
  end

  always_comb begin
    x_full = 25'(y4_r) * 25'(RECIP255);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      s5_r.valid <= 1'b0;
    end else if (ce) begin
      v3_r       <= stage_i.valid;
      v4_r       <= v3_r;
      s5_r.valid <= v4_r;
    end
    if (ce) begin
      sec3_r      <= stage_i.sector;
      b3_r        <= stage_i.bright;
      a3_r        <= stage_i.prod_a;
      t3_r        <= t3_nxt;
      q3_r        <= q3_nxt;
      g3_r        <= g3_nxt;
      sec4_r      <= sec3_r;
      b4_r        <= b3_r;
      y4_r        <= y4_nxt;
      g4_r        <= g4_nxt;
      s5_r.sector <= sec4_r;
      s5_r.bright <= b4_r;
      s5_r.gray   <= g4_r;
      s5_r.y      <= y4_r;
      s5_r.xest   <= x_full[23:16];
    end
  end

  assign stage_o = s5_r;

  // reciprocal estimates never overshoot
  a_q15_low: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> 21'(q3_r) * 21'(15) <= 21'(t3_r))
    else $error("divide-by-15 estimate too high");

  a_g_low: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> 17'(g3_r) * 17'(FULL_SCALE) <= 17'(a3_r))
    else $error("divide-by-255 estimate too high");

  a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> y4_r <= 16'd65025)
    else $error("x numerator quotient out of range");

endmodule

>>> hw/rtl/hsv_to_rgb_pixel_core.sv
// Top level of the HSV to RGB pixel converter: final correction, sector select
// and output register. Depends on hsvrgb_pkg, hsvrgb_prep, hsvrgb_quot.
//
// Usage:
//   Input stream (in_*): one HSV pixel per transfer. in_tdata carries hue in
//   1/128 degree units, saturation and brightness as fractions of 255.
//   Output stream (out_*): one RGB pixel per input transfer, in order.
//   Throughput: one pixel per clock while the output side does not stall;
//   the six register stages (sector/products, b*s*w multiply, reciprocal
//   estimates, quotient correction, y/255 estimate, select/output) all
//   advance together.
//   Stall: the whole pipeline holds while out_tvalid is high and out_tready
//   is low; in_tready drops in the same cycle, so no pixel is lost or
//   repeated. Empty slots (bubbles) travel through and cost nothing.
//   Reset (rst_n low, synchronous): clears every stage valid bit; data
//   registers are left as they are. No state is kept between pixels.
//   Hue of 46080 (360 degrees) and above gives gray: all channels equal
//   floor(b*(255-s)/255).
module hsv_to_rgb_pixel_core
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] hue, [23:16] saturation, [31:24] brightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  logic               ce;
  prep_t              prep_s;
  quot_t              quot_s;

  logic [PROD_W-1:0]  remx;
  logic [CHAN_W-1:0]  xv;
  logic [CHAN_W-1:0]  red_nxt, green_nxt, blue_nxt;
  logic               out_valid_r;
  logic [23:0]        out_data_r, out_data_nxt;

  // Global advance: the output register is free or being drained this cycle.
  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  hsvrgb_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_valid   (in_tvalid),
    .hue        (in_tdata[15:0]),
    .saturation (in_tdata[23:16]),
    .brightness (in_tdata[31:24]),
    .stage_o    (prep_s)
  );

  hsvrgb_quot u_quot (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .stage_i (prep_s),
    .stage_o (quot_s)
  );

  // Final correction of x = y/255, then place chroma (= brightness), x and gray.
  always_comb begin
    remx = quot_s.y - PROD_W'(quot_s.xest) * PROD_W'(FULL_SCALE);
    xv   = quot_s.xest + CHAN_W'(remx >= PROD_W'(FULL_SCALE));
    case (quot_s.sector)
      3'd0: begin
        red_nxt = quot_s.bright; green_nxt = xv;            blue_nxt = quot_s.gray;
      end
      3'd1: begin
        red_nxt = xv;            green_nxt = quot_s.bright; blue_nxt = quot_s.gray;
      end
      3'd2: begin
        red_nxt = quot_s.gray;   green_nxt = quot_s.bright; blue_nxt = xv;
      end
      3'd3: begin
        red_nxt = quot_s.gray;   green_nxt = xv;            blue_nxt = quot_s.bright;
      end
      3'd4: begin
        red_nxt = xv;            green_nxt = quot_s.gray;   blue_nxt = quot_s.bright;
      end
      3'd5: begin
        red_nxt = quot_s.bright; green_nxt = quot_s.gray;   blue_nxt = xv;
      end
      default: begin
        // hue at or past 360 degrees
        red_nxt = quot_s.gray;   green_nxt = quot_s.gray;   blue_nxt = quot_s.gray;
      end
    endcase
    out_data_nxt = {blue_nxt, green_nxt, red_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= quot_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // x always lies between gray and chroma
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    quot_s.valid |-> (xv >= quot_s.gray) && (xv <= quot_s.bright))
    else $error("x channel outside gray..chroma");

  // gray default drives all channels equal
  a_gray_out: assert property (@(posedge clk) disable iff (!rst_n)
    ce && quot_s.valid && quot_s.sector == SECTOR_GRAY |=>
      out_tdata[7:0] == out_tdata[15:8] && out_tdata[7:0] == out_tdata[23:16])
    else $error("gray sector gave unequal channels");

  // a held pixel is not overwritten while the pipeline is frozen
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(quot_s.y) && $stable(quot_s.sector) && $stable(prep_s.prod_bw))
    else $error("pipeline moved during stall");

endmodule

>>> dv/hsv_to_rgb_pixel_core_test.sv
// Self-checking testbench for hsv_to_rgb_pixel_core: directed corner pixels, then random
// HSV traffic with random stalls on both streams, checked against an in-bench predictor.
// Depends on hsvrgb_pkg and the hsv_to_rgb_pixel_core RTL.
module hsv_to_rgb_pixel_core_test
  import hsvrgb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PIXELS = 1500;
  localparam int unsigned IDLE_LIMIT    = 3000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES  = 12;    // pipeline is 6 deep
  localparam int unsigned PAUSE_AT      = 700;   // sender waits for an empty pipe here

  // Sector codes as used by the hue wheel; anything past the sixth is gray
  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5,
    SEC_GRAY_OUT = SECTOR_GRAY
  } hue_sector_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] bright;
    logic [CHAN_W-1:0] sat;
    logic [HUE_W-1:0]  hue;
  } hsv_t;

  // One directed stimulus row; rgb is used only when typed_in is set
  typedef struct {
    hsv_t pix;
    bit   typed_in;
    rgb_t rgb;
  } corner_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  rgb_t        rgb_expected_q[$];
  corner_row_t corner_rows[$];
  int unsigned error_count;
  int unsigned pixels_sent;
  int unsigned pixels_checked;
  int unsigned idle_cycles;
  bit          no_gaps;  // set during burst stretches: neither side idles

  hsv_to_rgb_pixel_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Chroma/sector conversion, exact in integer form with truncating divides.
  function automatic rgb_t hsv_to_rgb_expected(hsv_t pix);
    logic [63:0] b, s, span, phase, fold, weight, numer, gray, xval;
    hue_sector_e sec;
    rgb_t        px;
    b    = 64'(pix.bright);
    s    = 64'(pix.sat);
    span = 64'(SECTOR_CODES);
    gray = (b * (64'(FULL_SCALE) - s)) / 64'(FULL_SCALE);
    // triangle weight: 0 at even sector edges, full span at odd ones
    phase  = 64'(pix.hue) % (2 * span);
    fold   = (phase >= span) ? (phase - span) : (span - phase);
    weight = span - fold;
    numer  = b * (64'(FULL_SCALE) - s) * span + b * s * weight;
    xval   = numer / (64'(FULL_SCALE) * span);
    if (64'(pix.hue) >= 6 * span) begin
      sec = SEC_GRAY_OUT;
    end else begin
      sec = hue_sector_e'(64'(pix.hue) / span);
    end
    case (sec)
      SEC_RED_YEL: px = '{blue: gray[7:0],      green: xval[7:0],     red: pix.bright};
      SEC_YEL_GRN: px = '{blue: gray[7:0],      green: pix.bright,    red: xval[7:0]};
      SEC_GRN_CYN: px = '{blue: xval[7:0],      green: pix.bright,    red: gray[7:0]};
      SEC_CYN_BLU: px = '{blue: pix.bright,     green: xval[7:0],     red: gray[7:0]};
      SEC_BLU_MAG: px = '{blue: pix.bright,     green: gray[7:0],     red: xval[7:0]};
      SEC_MAG_RED: px = '{blue: xval[7:0],      green: gray[7:0],     red: pix.bright};
      default:     px = '{blue: gray[7:0],      green: gray[7:0],     red: gray[7:0]};
    endcase
    return px;
  endfunction

  function automatic corner_row_t corner(int hue, int sat, int bright, bit typed_in = 1'b0,
                                         int r = 0, int g = 0, int bl = 0);
    corner_row_t row;
    row.pix      = '{bright: bright[7:0], sat: sat[7:0], hue: hue[15:0]};
    row.typed_in = typed_in;
    row.rgb      = '{blue: bl[7:0], green: g[7:0], red: r[7:0]};
    return row;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned gap_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end else if (pick < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic hsv_t random_pixel();
    hsv_t        pix;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      pix.hue = 16'($urandom_range(0, 46079));
    end else if (pick < 80) begin
      // hug a sector edge, including the wrap into gray
      pix.hue = 16'($urandom_range(0, 6) * 7680 + $urandom_range(0, 4) - 2);
    end else if (pick < 90) begin
      pix.hue = 16'($urandom_range(46080, 65535));
    end else begin
      pix.hue = 16'($urandom);
    end
    pix.sat    = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255)
                                             : 8'($urandom);
    pix.bright = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255)
                                             : 8'($urandom);
    return pix;
  endfunction

  // Present one pixel from a falling edge, hold it until the transfer, then return on the
  // following falling edge with in_tvalid still high.
  task automatic send_pixel(hsv_t pix, bit typed_in, rgb_t typed_rgb);
    in_tvalid = 1'b1;
    in_tdata  = pix;
    do begin
      @(posedge clk);
    end while (!in_tready);
    rgb_expected_q.push_back(typed_in ? typed_rgb : hsv_to_rgb_expected(pix));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input(int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Sink side: random backpressure, changed only on falling edges
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      stall      = gap_cycles();
      if (stall != 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Output checker: every result transfer is matched with the oldest expectation
  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (rgb_expected_q.size() == 0) begin
        $display("%0t: unexpected pixel out, got r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        error_count++;
      end else begin
        want = rgb_expected_q.pop_front();
        pixels_checked++;
        if (got.red !== want.red) begin
          $display("%0t: red mismatch, expected %0d got %0d", $time, want.red, got.red);
          error_count++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green mismatch, expected %0d got %0d", $time, want.green, got.green);
          error_count++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue mismatch, expected %0d got %0d", $time, want.blue, got.blue);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a run with no transfer on either side for too long is hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("hsv_to_rgb_pixel_core_test: errors");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    no_gaps        = 1'b0;
    error_count    = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    idle_cycles    = 0;

    // corner pixels: fully saturated primaries/secondaries at sector edges are obvious
    corner_rows.push_back(corner(0,     0,   0,   1'b1, 0,   0,   0));
    corner_rows.push_back(corner(0,     255, 255, 1'b1, 255, 0,   0));
    corner_rows.push_back(corner(7680,  255, 255, 1'b1, 255, 255, 0));
    corner_rows.push_back(corner(15360, 255, 255, 1'b1, 0,   255, 0));
    corner_rows.push_back(corner(23040, 255, 255, 1'b1, 0,   255, 255));
    corner_rows.push_back(corner(30720, 255, 255, 1'b1, 0,   0,   255));
    corner_rows.push_back(corner(38400, 255, 255, 1'b1, 255, 0,   255));
    // hue of a full turn or more: gray level, zero at full saturation
    corner_rows.push_back(corner(46080, 255, 255, 1'b1, 0,   0,   0));
    corner_rows.push_back(corner(65535, 0,   255, 1'b1, 255, 255, 255));
    // zero saturation: every channel is brightness
    corner_rows.push_back(corner(12345, 0,   200, 1'b1, 200, 200, 200));
    corner_rows.push_back(corner(40000, 0,   1,   1'b1, 1,   1,   1));
    // values that need the full arithmetic
    corner_rows.push_back(corner(7679,  255, 255));
    corner_rows.push_back(corner(15359, 128, 200));
    corner_rows.push_back(corner(3840,  255, 255));
    corner_rows.push_back(corner(19200, 170, 99));
    corner_rows.push_back(corner(26880, 1,   254));
    corner_rows.push_back(corner(34560, 254, 1));
    corner_rows.push_back(corner(42240, 85,  255));
    corner_rows.push_back(corner(46079, 200, 180));
    corner_rows.push_back(corner(46080, 128, 200));
    corner_rows.push_back(corner(65535, 255, 255));
    corner_rows.push_back(corner(65535, 128, 200));
    corner_rows.push_back(corner(1,     37,  211));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (corner_rows[i]) begin
      send_pixel(corner_rows[i].pix, corner_rows[i].typed_in, corner_rows[i].rgb);
      idle_input(gap_cycles());
    end

    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      // two stretches run at full rate with no stalls on either side
      no_gaps = (n >= 300 && n < 450) || (n >= 1100 && n < 1200);
      if (n == PAUSE_AT) begin
        in_tvalid = 1'b0;
        wait (rgb_expected_q.size() == 0);
        @(negedge clk);
      end
      send_pixel(random_pixel(), 1'b0, '0);
      idle_input(gap_cycles());
    end
    no_gaps   = 1'b0;
    in_tvalid = 1'b0;

    while (rgb_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pixels sent, %0d checked: sector edges, gray hues, flat saturation,",
             pixels_sent, pixels_checked);
    $display("random hues across the 16-bit range, under random stalls on both streams");
    if (error_count == 0) begin
      $display("hsv_to_rgb_pixel_core_test: clean");
    end else begin
      $display("hsv_to_rgb_pixel_core_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_prep.sv
hw/rtl/hsvrgb_quot.sv
hw/rtl/hsv_to_rgb_pixel_core.sv
dv/hsv_to_rgb_pixel_core_test.sv
